[rtl/core/htbc_pkg.sv]
// shared types and constants for the huffman tree builder and coder
`timescale 1ns / 1ps

package htbc_pkg;

    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_BUILD  = 2'd1;
    localparam logic [1:0] ACT_ENCODE = 2'd2;
    localparam logic [1:0] ACT_DECODE = 2'd3;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_TOOLONG  = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  symbol;
        logic [31:0] leaf_weight;
        logic [31:0] query_code;
        logic [5:0]  query_length;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  out_symbol;
        logic [31:0] code_bits;
        logic [5:0]  code_length;
    } result_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_LOAD,
        OP_SWEEP_START,
        OP_SWEEP,
        OP_SCAN_START,
        OP_SCAN,
        OP_MERGE1,
        OP_MERGE2,
        OP_MERGE3,
        OP_ROOT,
        OP_PUSH_ROOT,
        OP_POP,
        OP_NODE,
        OP_PUSH_R,
        OP_PUSH_L,
        OP_UP_START,
        OP_UP_B,
        OP_UP_C,
        OP_D_START,
        OP_D_MOVE,
        OP_REPLY
    } op_t;

    typedef struct packed {
        op_t     op;
        status_t code;
    } cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       lc_full;
        logic       lc_zero;
        logic       sweep_last;
        logic       build_done;
        logic       scan_done;
        logic       sp_zero;
        logic       is_leaf;
        logic       sym_match;
        logic       at_root;
        logic       depth_max;
        logic       q_too_long;
        logic       q_end;
        logic       built;
    } dp_stat_t;

endpackage

[rtl/core/htbc_ctrl.sv]
// control state machine sequencing load, build, encode and decode
`timescale 1ns / 1ps

module htbc_ctrl
    import htbc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t stat,
    output cmd_t     cmd,
    output logic     busy
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_OK,
        S_SWEEP,
        S_MCHECK,
        S_SCAN,
        S_MERGE1,
        S_MERGE2,
        S_MERGE3,
        S_E_POP,
        S_E_NODE,
        S_E_TEST,
        S_E_PUSHL,
        S_U_CHECK,
        S_U_A,
        S_U_B,
        S_U_C,
        S_D_WAIT,
        S_D_STEP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        cmd.code   = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_LATCH;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (stat.action)
                    ACT_LOAD:
                    begin
                        if (stat.lc_full)
                        begin
                            cmd.op     = OP_REPLY;
                            cmd.code   = ST_FULL;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.op     = OP_LOAD;
                            state_next = S_OK;
                        end
                    end
                    ACT_BUILD:
                    begin
                        if (stat.lc_zero)
                        begin
                            cmd.op     = OP_REPLY;
                            cmd.code   = ST_FULL;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.op     = OP_SWEEP_START;
                            state_next = S_SWEEP;
                        end
                    end
                    ACT_ENCODE:
                    begin
                        if (!stat.built)
                        begin
                            cmd.op     = OP_REPLY;
                            cmd.code   = ST_FULL;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.op     = OP_PUSH_ROOT;
                            state_next = S_E_POP;
                        end
                    end
                    ACT_DECODE:
                    begin
                        if (!stat.built)
                        begin
                            cmd.op     = OP_REPLY;
                            cmd.code   = ST_FULL;
                            state_next = S_IDLE;
                        end
                        else if (stat.q_too_long)
                        begin
                            cmd.op     = OP_REPLY;
                            cmd.code   = ST_TOOLONG;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.op     = OP_D_START;
                            state_next = S_D_WAIT;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_OK:
            begin
                cmd.op     = OP_REPLY;
                state_next = S_IDLE;
            end
            S_SWEEP:
            begin
                cmd.op = OP_SWEEP;
                if (stat.sweep_last)
                begin
                    state_next = S_MCHECK;
                end
            end
            S_MCHECK:
            begin
                if (stat.build_done)
                begin
                    cmd.op     = OP_ROOT;
                    state_next = S_OK;
                end
                else
                begin
                    cmd.op     = OP_SCAN_START;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.op = OP_SCAN;
                if (stat.scan_done)
                begin
                    state_next = S_MERGE1;
                end
            end
            S_MERGE1:
            begin
                cmd.op     = OP_MERGE1;
                state_next = S_MERGE2;
            end
            S_MERGE2:
            begin
                cmd.op     = OP_MERGE2;
                state_next = S_MERGE3;
            end
            S_MERGE3:
            begin
                cmd.op     = OP_MERGE3;
                state_next = S_MCHECK;
            end
            S_E_POP:
            begin
                if (stat.sp_zero)
                begin
                    cmd.op     = OP_REPLY;
                    cmd.code   = ST_NOTFOUND;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op     = OP_POP;
                    state_next = S_E_NODE;
                end
            end
            S_E_NODE:
            begin
                cmd.op     = OP_NODE;
                state_next = S_E_TEST;
            end
            S_E_TEST:
            begin
                if (stat.is_leaf)
                begin
                    if (stat.sym_match)
                    begin
                        cmd.op     = OP_UP_START;
                        state_next = S_U_CHECK;
                    end
                    else
                    begin
                        state_next = S_E_POP;
                    end
                end
                else
                begin
                    cmd.op     = OP_PUSH_R;
                    state_next = S_E_PUSHL;
                end
            end
            S_E_PUSHL:
            begin
                cmd.op     = OP_PUSH_L;
                state_next = S_E_POP;
            end
            S_U_CHECK:
            begin
                if (stat.at_root)
                begin
                    cmd.op     = OP_REPLY;
                    state_next = S_IDLE;
                end
                else if (stat.depth_max)
                begin
                    cmd.op     = OP_REPLY;
                    cmd.code   = ST_TOOLONG;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_U_A;
                end
            end
            S_U_A:
            begin
                state_next = S_U_B;
            end
            S_U_B:
            begin
                cmd.op     = OP_UP_B;
                state_next = S_U_C;
            end
            S_U_C:
            begin
                cmd.op     = OP_UP_C;
                state_next = S_U_CHECK;
            end
            S_D_WAIT:
            begin
                state_next = S_D_STEP;
            end
            S_D_STEP:
            begin
                if (stat.q_end)
                begin
                    cmd.op     = OP_REPLY;
                    cmd.code   = stat.is_leaf ? ST_OK : ST_NOTFOUND;
                    state_next = S_IDLE;
                end
                else if (stat.is_leaf)
                begin
                    cmd.op     = OP_REPLY;
                    cmd.code   = ST_NOTFOUND;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op     = OP_D_MOVE;
                    state_next = S_D_WAIT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

[rtl/core/htbc_dpath.sv]
// datapath with node stores, walk stack, counters and result register
`timescale 1ns / 1ps

module htbc_dpath
    import htbc_pkg::*;
#(
    parameter int MAX_LEAVES   = 256,
    parameter int MAX_CODE_LEN = 32
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  item_t    item,
    input  cmd_t     cmd,
    output dp_stat_t stat,
    output logic     done,
    output result_t  result
);

    localparam int NW         = $clog2(2 * MAX_LEAVES);
    localparam int LW         = $clog2(MAX_LEAVES);
    localparam int NODES      = 2 * MAX_LEAVES - 1;
    localparam int SDEPTH     = 2 * MAX_LEAVES;
    localparam int CODE_LIMIT = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;

    logic [7:0]    sym_mem   [0:MAX_LEAVES-1];
    logic [31:0]   wt_mem    [0:NODES-1];
    logic [NW-1:0] left_mem  [0:NODES-1];
    logic [NW-1:0] right_mem [0:NODES-1];
    logic [NW:0]   up_mem    [0:NODES-1];
    logic [NW-1:0] stk_mem   [0:SDEPTH-1];

    logic [7:0]    sym_rd;
    logic [31:0]   wt_rd;
    logic [NW-1:0] left_rd;
    logic [NW-1:0] right_rd;
    logic [NW:0]   up_rd;
    logic [NW-1:0] stk_rd;

    item_t         item_reg;
    logic [NW-1:0] lc_reg;
    logic [NW-1:0] root_reg;
    logic          built_reg;
    logic [NW-1:0] next_reg;
    logic [NW-1:0] cnt_reg;
    logic [NW-1:0] sp_reg;
    logic [NW-1:0] node_reg;
    logic [NW-1:0] child_reg;
    logic [5:0]    qi_reg;
    logic [5:0]    depth_reg;
    logic [31:0]   bits_reg;
    logic          pv_reg;
    logic [NW-1:0] pidx_reg;
    logic          b1v_reg;
    logic          b2v_reg;
    logic [31:0]   b1w_reg;
    logic [31:0]   b2w_reg;
    logic [NW-1:0] b1i_reg;
    logic [NW-1:0] b2i_reg;
    logic          done_reg;
    result_t       result_reg;

    logic [NW-1:0] node_addr;
    logic [NW-1:0] scan_addr;
    logic [NW-1:0] last_node;
    logic [5:0]    qpos;
    logic          alive;
    logic          lt1;
    logic          lt2;
    logic          is_ok;

    assign node_addr = (cmd.op == OP_NODE) ? stk_rd :
                       (cmd.op == OP_UP_B) ? up_rd[NW-1:0] : node_reg;
    assign scan_addr = (cmd.op == OP_SCAN) ? cnt_reg : node_reg;
    assign last_node = NW'((lc_reg << 1) - NW'(1));
    assign qpos      = item_reg.query_length - 6'd1 - qi_reg;
    assign alive     = pv_reg && !up_rd[NW];
    assign lt1       = !b1v_reg || (wt_rd < b1w_reg);
    assign lt2       = !b2v_reg || (wt_rd < b2w_reg);
    assign is_ok     = (cmd.code == ST_OK);

    // node stores
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            sym_mem[lc_reg[LW-1:0]] <= item_reg.symbol;
        end
        sym_rd <= sym_mem[node_addr[LW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            wt_mem[lc_reg] <= item_reg.leaf_weight;
        end
        else if (cmd.op == OP_MERGE1)
        begin
            wt_mem[next_reg] <= b1w_reg + b2w_reg;
        end
        wt_rd <= wt_mem[cnt_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_MERGE1)
        begin
            left_mem[next_reg]  <= b2i_reg;
            right_mem[next_reg] <= b1i_reg;
        end
        left_rd  <= left_mem[node_addr];
        right_rd <= right_mem[node_addr];
    end

    // parent link with a removed flag on top
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_SWEEP:  up_mem[cnt_reg]  <= '0;
            OP_MERGE1: up_mem[b1i_reg]  <= {1'b1, next_reg};
            OP_MERGE2: up_mem[b2i_reg]  <= {1'b1, next_reg};
            OP_MERGE3: up_mem[next_reg] <= '0;
            default:   ;
        endcase
        up_rd <= up_mem[scan_addr];
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_PUSH_ROOT: stk_mem[NW'(0)] <= root_reg;
            OP_PUSH_R:    stk_mem[sp_reg] <= right_rd;
            OP_PUSH_L:    stk_mem[sp_reg] <= left_rd;
            default:      ;
        endcase
        stk_rd <= stk_mem[NW'(sp_reg - NW'(1))];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lc_reg    <= '0;
            root_reg  <= '0;
            built_reg <= 1'b0;
            next_reg  <= '0;
            cnt_reg   <= '0;
            sp_reg    <= '0;
            qi_reg    <= '0;
            depth_reg <= '0;
            pv_reg    <= 1'b0;
            b1v_reg   <= 1'b0;
            b2v_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (cmd.op == OP_REPLY);
            pv_reg   <= 1'b0;
            unique case (cmd.op)
                OP_LATCH:
                begin
                    depth_reg <= '0;
                end
                OP_LOAD:
                begin
                    lc_reg    <= lc_reg + NW'(1);
                    built_reg <= 1'b0;
                end
                OP_SWEEP_START:
                begin
                    cnt_reg  <= '0;
                    next_reg <= lc_reg;
                end
                OP_SWEEP:
                begin
                    cnt_reg <= cnt_reg + NW'(1);
                end
                OP_SCAN_START:
                begin
                    cnt_reg <= '0;
                    b1v_reg <= 1'b0;
                    b2v_reg <= 1'b0;
                end
                OP_SCAN:
                begin
                    if (cnt_reg != next_reg)
                    begin
                        cnt_reg <= cnt_reg + NW'(1);
                        pv_reg  <= 1'b1;
                    end
                    if (alive)
                    begin
                        if (lt1)
                        begin
                            b1v_reg <= 1'b1;
                            b2v_reg <= b1v_reg;
                        end
                        else if (lt2)
                        begin
                            b2v_reg <= 1'b1;
                        end
                    end
                end
                OP_MERGE3:
                begin
                    next_reg <= next_reg + NW'(1);
                end
                OP_ROOT:
                begin
                    root_reg  <= NW'(next_reg - NW'(1));
                    built_reg <= 1'b1;
                end
                OP_PUSH_ROOT:
                begin
                    sp_reg <= NW'(1);
                end
                OP_POP:
                begin
                    sp_reg <= sp_reg - NW'(1);
                end
                OP_PUSH_R, OP_PUSH_L:
                begin
                    sp_reg <= sp_reg + NW'(1);
                end
                OP_UP_START:
                begin
                    depth_reg <= '0;
                end
                OP_UP_C:
                begin
                    depth_reg <= depth_reg + 6'd1;
                end
                OP_D_START:
                begin
                    qi_reg <= '0;
                end
                OP_D_MOVE:
                begin
                    qi_reg <= qi_reg + 6'd1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pidx_reg <= cnt_reg;
        unique case (cmd.op)
            OP_LATCH:
            begin
                item_reg <= item;
                bits_reg <= '0;
            end
            OP_SCAN:
            begin
                if (alive)
                begin
                    if (lt1)
                    begin
                        b1w_reg <= wt_rd;
                        b1i_reg <= pidx_reg;
                        b2w_reg <= b1w_reg;
                        b2i_reg <= b1i_reg;
                    end
                    else if (lt2)
                    begin
                        b2w_reg <= wt_rd;
                        b2i_reg <= pidx_reg;
                    end
                end
            end
            OP_NODE:
            begin
                node_reg <= stk_rd;
            end
            OP_UP_START:
            begin
                bits_reg <= '0;
            end
            OP_UP_B:
            begin
                child_reg <= node_reg;
                node_reg  <= up_rd[NW-1:0];
            end
            OP_UP_C:
            begin
                if (right_rd == child_reg)
                begin
                    bits_reg[depth_reg[4:0]] <= 1'b1;
                end
            end
            OP_D_START:
            begin
                node_reg <= root_reg;
            end
            OP_D_MOVE:
            begin
                node_reg <= item_reg.query_code[qpos[4:0]] ? right_rd : left_rd;
            end
            OP_REPLY:
            begin
                result_reg.status      <= cmd.code;
                result_reg.out_symbol  <= (is_ok && item_reg.action == ACT_DECODE) ?
                                          sym_rd : 8'd0;
                result_reg.code_bits   <= (is_ok && item_reg.action == ACT_ENCODE) ?
                                          bits_reg : 32'd0;
                result_reg.code_length <= (is_ok && item_reg.action == ACT_ENCODE) ?
                                          depth_reg : 6'd0;
            end
            default:
            begin
            end
        endcase
    end

    assign stat.action     = item_reg.action;
    assign stat.lc_full    = (lc_reg == NW'(MAX_LEAVES));
    assign stat.lc_zero    = (lc_reg == '0);
    assign stat.sweep_last = (cnt_reg == NW'(lc_reg - NW'(1)));
    assign stat.build_done = (next_reg == last_node);
    assign stat.scan_done  = (cnt_reg == next_reg) && !pv_reg;
    assign stat.sp_zero    = (sp_reg == '0);
    assign stat.is_leaf    = (node_reg < lc_reg);
    assign stat.sym_match  = (sym_rd == item_reg.symbol);
    assign stat.at_root    = (node_reg == root_reg);
    assign stat.depth_max  = (depth_reg == 6'(CODE_LIMIT));
    assign stat.q_too_long = (item_reg.query_length > 6'(CODE_LIMIT));
    assign stat.q_end      = (qi_reg == item_reg.query_length);
    assign stat.built      = built_reg;

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[rtl/core/huffman_tree_build_and_code.sv]
// huffman tree builder and coder top level
//
//   channel   ports                 transfer
//   command   start, busy, item     start high while busy low
//   result    done, result          done high for one cycle, no back-pressure
//
// build makes n-1 merges for n leaves: each merge scans every node made
// so far through the one read port of the weight store. encode walks the
// tree depth-first to find the leaf, then climbs its parent links to gather
// the code bits; decode follows the query bits down from the root. no
// clearing pass follows reset.
`timescale 1ns / 1ps

module huffman_tree_build_and_code
    import htbc_pkg::*;
#(
    parameter int MAX_LEAVES   = 256,
    parameter int MAX_CODE_LEN = 32
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  item_t   item,
    output logic    done,
    output result_t result
);

    cmd_t     cmd;
    dp_stat_t stat;

    htbc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    htbc_dpath #(
        .MAX_LEAVES   (MAX_LEAVES),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .done   (done),
        .result (result)
    );

endmodule

[tb/tb.sv]
// self-checking testbench for the huffman tree builder and coder
`timescale 1ns / 1ps

module tb;
    import htbc_pkg::*;

    localparam int LEAF_CAP  = 256;
    localparam int NODE_CAP  = 2 * LEAF_CAP - 1;
    localparam int CODE_CAP  = 32;

    class huff_scoreboard;
        result_t     pending[$];
        int          errors;
        int          checked;
        int          status_seen[4];
        bit [7:0]    sym_of[LEAF_CAP];
        bit [31:0]   weight_of[NODE_CAP];
        int          left_of[NODE_CAP];
        int          right_of[NODE_CAP];
        int          parent_of[NODE_CAP];
        int          order[NODE_CAP];
        int          n_leaves;
        int          root;
        bit          built;

        function new();
            errors = 0;
            checked = 0;
            n_leaves = 0;
            root = 0;
            built = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function int take_lowest(inout int len);
            int best;
            int pick;
            best = 0;
            for (int i = 1; i < len; i++)
                if (weight_of[order[i]] < weight_of[order[best]])
                    best = i;
            pick = order[best];
            for (int i = best; i + 1 < len; i++)
                order[i] = order[i + 1];
            len--;
            return pick;
        endfunction

        function void merge_all();
            int len;
            int next;
            int r;
            int l;
            len = n_leaves;
            next = n_leaves;
            for (int i = 0; i < n_leaves; i++) order[i] = i;
            while (len > 1 && next < NODE_CAP) begin
                r = take_lowest(len);
                l = take_lowest(len);
                weight_of[next] = weight_of[l] + weight_of[r];
                left_of[next] = l;
                right_of[next] = r;
                parent_of[l] = next;
                parent_of[r] = next;
                order[len] = next;
                len++;
                next++;
            end
            root = order[0];
            built = 1;
        endfunction

        function result_t predict(item_t it);
            result_t res;
            int      stack[$];
            int      node;
            int      hit;
            int      depth;
            int      pos;
            bit      found;
            bit      early;
            res = '0;
            res.status = ST_OK;
            if (it.action == ACT_LOAD) begin
                if (n_leaves >= LEAF_CAP) res.status = ST_FULL;
                else begin
                    sym_of[n_leaves] = it.symbol;
                    weight_of[n_leaves] = it.leaf_weight;
                    n_leaves++;
                    built = 0;
                end
            end else if (it.action == ACT_BUILD) begin
                if (n_leaves == 0) res.status = ST_FULL;
                else merge_all();
            end else if (!built) begin
                res.status = ST_FULL;
            end else if (it.action == ACT_ENCODE) begin
                found = 0;
                hit = 0;
                stack = {stack, root};
                while (stack.size() > 0) begin
                    node = stack.pop_back();
                    if (node < n_leaves) begin
                        if (sym_of[node] == it.symbol) begin
                            found = 1;
                            hit = node;
                            break;
                        end
                    end else begin
                        stack = {stack, right_of[node]};
                        stack = {stack, left_of[node]};
                    end
                end
                if (!found) res.status = ST_NOTFOUND;
                else begin
                    depth = 0;
                    for (node = hit; node != root; node = parent_of[node]) depth++;
                    if (depth > CODE_CAP) res.status = ST_TOOLONG;
                    else begin
                        pos = 0;
                        for (node = hit; node != root; node = parent_of[node]) begin
                            if (right_of[parent_of[node]] == node)
                                res.code_bits[pos] = 1'b1;
                            pos++;
                        end
                        res.code_length = 6'(depth);
                    end
                end
            end else begin
                if (it.query_length > CODE_CAP) res.status = ST_TOOLONG;
                else begin
                    node = root;
                    early = 0;
                    for (int i = 0; i < it.query_length; i++) begin
                        if (node < n_leaves) begin
                            early = 1;
                            break;
                        end
                        node = it.query_code[it.query_length - 1 - i] ?
                               right_of[node] : left_of[node];
                    end
                    if (early || node >= n_leaves) res.status = ST_NOTFOUND;
                    else res.out_symbol = sym_of[node];
                end
            end
            return res;
        endfunction

        function void note(item_t it);
            pending = {pending, predict(it)};
        endfunction

        function void check(result_t got);
            result_t want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %p with nothing pending", got);
                return;
            end
            want = pending.pop_front();
            checked++;
            status_seen[want.status]++;
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch at %0t: expected %p, got %p", $realtime, want, got);
            end
        endfunction

        // random path from the root down to a leaf, cut off after CODE_CAP steps
        function void leaf_path(output bit [31:0] code, output int len);
            int node;
            bit b;
            node = root;
            code = '0;
            len = 0;
            while (node >= n_leaves && len < CODE_CAP) begin
                b = 1'($urandom_range(0, 1));
                code = {code[30:0], b};
                node = b ? right_of[node] : left_of[node];
                len++;
            end
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    item_t   item;
    logic    done;
    result_t result;

    huff_scoreboard sb;
    int             n_sent;

    huffman_tree_build_and_code i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        if (rst_n && done) sb.check(result);
    end

    function automatic bit [31:0] pick_weight();
        case ($urandom_range(0, 4))
            0: return 32'h0;
            1: return 32'hffff_ffff;
            2: return $urandom_range(1, 16);
            default: return $urandom;
        endcase
    endfunction

    function automatic item_t blank_item(logic [1:0] act);
        item_t it;
        it.action       = act;
        it.symbol       = 8'($urandom);
        it.leaf_weight  = $urandom;
        it.query_code   = $urandom;
        it.query_length = 6'($urandom);
        return it;
    endfunction

    task automatic send(item_t it);
        @(negedge clk);
        start <= 1'b1;
        item  <= it;
        do @(posedge clk); while (busy);
        sb.note(it);
        n_sent++;
    endtask

    task automatic hold_off(bit quiet);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending.size() > 0) @(posedge clk);
    endtask

    task automatic load(logic [7:0] sym, logic [31:0] w, bit quiet);
        item_t it;
        it = blank_item(ACT_LOAD);
        it.symbol = sym;
        it.leaf_weight = w;
        send(it);
        hold_off(quiet);
    endtask

    task automatic op(logic [1:0] act, bit quiet);
        send(blank_item(act));
        hold_off(quiet);
    endtask

    task automatic encode(logic [7:0] sym, bit quiet);
        item_t it;
        it = blank_item(ACT_ENCODE);
        it.symbol = sym;
        send(it);
        hold_off(quiet);
    endtask

    task automatic decode(bit [31:0] code, int len, bit quiet);
        item_t it;
        it = blank_item(ACT_DECODE);
        if (len < 32) code |= $urandom << len;
        it.query_code = code;
        it.query_length = 6'(len);
        send(it);
        hold_off(quiet);
    endtask

    task automatic random_query(bit quiet);
        bit [31:0] code;
        int        len;
        int        pick;
        pick = $urandom_range(0, 19);
        if (pick == 0 && sb.n_leaves < 100) op(ACT_BUILD, quiet);
        else if (pick == 1) begin
            load(8'($urandom), pick_weight(), quiet);
            if ($urandom_range(0, 1) && sb.n_leaves < 100) op(ACT_BUILD, quiet);
        end else if (pick < 10) begin
            if ($urandom_range(0, 4) != 0 && sb.n_leaves > 0)
                encode(sb.sym_of[$urandom_range(0, sb.n_leaves - 1)], quiet);
            else
                encode(8'($urandom), quiet);
        end else if (pick < 16) begin
            sb.leaf_path(code, len);
            decode(code, len, quiet);
        end else if (pick < 18) begin
            sb.leaf_path(code, len);
            len = (len == 0 || $urandom_range(0, 1)) ? len + 1 : len - 1;
            decode(code, len, quiet);
        end else begin
            decode($urandom, $urandom_range(0, 63), quiet);
        end
    endtask

    initial
    begin
        #100ms;
        $display("timeout with %0d results still pending", sb.pending.size());
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int        targets[7];
        bit [31:0] code;
        int        len;
        bit        quiet;

        targets = '{40, 48, 64, 96, 128, 192, 256};
        sb = new();
        n_sent = 0;
        rst_n = 1'b0;
        start = 1'b0;
        item  = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty tree and queries before any build
        op(ACT_BUILD, 0);
        encode(8'h00, 0);
        decode(32'h0, 0, 0);
        // single leaf is its own root
        load(8'ha5, 32'h0, 0);
        op(ACT_BUILD, 0);
        encode(8'ha5, 0);
        encode(8'h5a, 0);
        decode(32'h0, 0, 0);
        decode(32'h1, 1, 0);
        decode($urandom, 33, 0);
        decode($urandom, 63, 0);
        // duplicate symbol, extreme weights, load after build
        load(8'h00, 32'hffff_ffff, 0);
        load(8'hff, 32'h1, 0);
        load(8'ha5, 32'h7, 0);
        encode(8'hff, 0);
        decode(32'h0, 1, 0);
        op(ACT_BUILD, 0);
        encode(8'h00, 0);
        encode(8'hff, 0);
        encode(8'ha5, 0);
        encode(8'h77, 0);
        repeat (4)
        begin
            sb.leaf_path(code, len);
            decode(code, len, 0);
        end
        drain();

        foreach (targets[s])
        begin
            quiet = (s == $size(targets) - 1);
            while (sb.n_leaves < targets[s])
            begin
                // the first stage builds a long chain of saturated weights
                load(8'($urandom), (s == 0) ? 32'hffff_ffff : pick_weight(), quiet);
                if ($urandom_range(0, 9) == 0) random_query(quiet);
            end
            op(ACT_BUILD, quiet);
            repeat (55) random_query(quiet);
            if (s == $size(targets) - 1)
            begin
                repeat (6) load(8'($urandom), pick_weight(), quiet);
                op(ACT_BUILD, quiet);
                repeat (20) random_query(quiet);
            end
            if (!quiet) drain();
        end

        drain();
        repeat (200) @(posedge clk);

        $display("%0d transfers sent, %0d results checked, tree grown to %0d leaves",
                 n_sent, sb.checked, sb.n_leaves);
        $display("status mix ok/not found/full or empty/too long: %0d/%0d/%0d/%0d",
                 sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3]);
        if (sb.errors == 0 && sb.pending.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("%0d errors", sb.errors);
            $display("Verification failed");
        end
        $finish;
    end
endmodule

[sim.f]
rtl/core/htbc_pkg.sv
rtl/core/htbc_ctrl.sv
rtl/core/htbc_dpath.sv
rtl/core/huffman_tree_build_and_code.sv
tb/tb.sv
